// ----- rtl/core/urrs_pkg.sv -----
// ----------------------------------------------------------------------------
// urrs_pkg
// Shared types and constants of the usable range reservation splitter.
// ----------------------------------------------------------------------------
package urrs_pkg;

  localparam int unsigned ADDR_W         = 64;
  localparam int unsigned CNT_W          = 8;
  localparam int unsigned TABLE_CAPACITY = 128;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_END   = 2'd2;

  localparam logic [CNT_W-1:0] TABLE_CAP_C = CNT_W'(TABLE_CAPACITY);

  typedef struct packed {
    logic [ADDR_W-1:0] entry_addr;
    logic [ADDR_W-1:0] entry_len;
    logic              entry_usable;
    logic              first_entry;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] piece_addr;
    logic [ADDR_W-1:0] piece_len;
    logic              piece_reserved;
    logic              piece_last;
    logic              table_overflow;
  } piece_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sec_base;
    logic [ADDR_W-1:0] win_open;
    logic [ADDR_W-1:0] win_close;
  } cfg_t;

  // mask[0]: usable below window (or whole span when single)
  // mask[1]: reserved overlap, mask[2]: usable above window
  typedef struct packed {
    logic [ADDR_W-1:0] span_start;
    logic [ADDR_W-1:0] span_last;
    logic              first;
    logic [2:0]        mask;
    logic              single;
    logic              start_gt_rs;
    logic              last_lt_rl;
  } job_t;

endpackage

// ----- rtl/core/urrs_front.sv -----
// ----------------------------------------------------------------------------
// urrs_front
// Two-stage classifier: clip entry to the section start, then locate it
// against the reserved window and emit a job descriptor.
// ----------------------------------------------------------------------------
module urrs_front import urrs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  entry_t in_data_i,
  output logic   job_valid_o,
  input  logic   job_ready_i,
  output job_t   job_o
);

  logic              s1_valid_q, s1_valid_d;
  logic [ADDR_W-1:0] s1_start_q, s1_last_q;
  logic              s1_keep_q, s1_first_q;
  logic              s2_valid_q, s2_valid_d;
  job_t              s2_job_q, s2_job_d;
  logic              s2_need;

  logic [ADDR_W:0]   sum;
  logic [ADDR_W-1:0] last_a, start_a, rlast;
  logic              keep_a, nowin;
  logic              s1_ready, s2_ready;

  assign sum     = {1'b0, in_data_i.entry_addr} + {1'b0, in_data_i.entry_len - ADDR_W'(1)};
  assign last_a  = sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
  assign start_a = (in_data_i.entry_addr < cfg_i.sec_base) ?
                   cfg_i.sec_base : in_data_i.entry_addr;
  assign keep_a  = in_data_i.entry_usable && (in_data_i.entry_len != '0) &&
                   !(last_a < cfg_i.sec_base);

  assign s2_need     = s2_job_q.first || (s2_job_q.mask != 3'b000);
  assign job_valid_o = s2_valid_q && s2_need;
  assign job_o       = s2_job_q;
  assign s2_ready    = !s2_valid_q || !s2_need || job_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign in_stall_o  = !s1_ready;

  assign rlast = cfg_i.win_close - ADDR_W'(1);
  assign nowin = (cfg_i.win_close <= cfg_i.win_open) ||
                 (cfg_i.win_close <= s1_start_q) ||
                 (s1_last_q < cfg_i.win_open);

  always_comb begin
    s2_job_d.span_start  = s1_start_q;
    s2_job_d.span_last   = s1_last_q;
    s2_job_d.first       = s1_first_q;
    s2_job_d.single      = nowin;
    s2_job_d.start_gt_rs = s1_start_q > cfg_i.win_open;
    s2_job_d.last_lt_rl  = s1_last_q < rlast;
    if (!s1_keep_q) begin
      s2_job_d.mask = 3'b000;
    end else if (nowin) begin
      s2_job_d.mask = 3'b001;
    end else begin
      s2_job_d.mask = {rlast < s1_last_q, 1'b1, s1_start_q < cfg_i.win_open};
    end
  end

  assign s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_start_q <= start_a;
      s1_last_q  <= last_a;
      s1_keep_q  <= keep_a;
      s1_first_q <= in_data_i.first_entry;
    end
    if (s2_ready && s1_valid_q) begin
      s2_job_q <= s2_job_d;
    end
  end

endmodule

// ----- rtl/core/urrs_queue.sv -----
// ----------------------------------------------------------------------------
// urrs_queue
// Small job FIFO between the classifier and the piece emitter.
// ----------------------------------------------------------------------------
module urrs_queue import urrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic head_valid_o,
  input  logic pop_i,
  output job_t head_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  assign wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
  assign rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
  assign cnt_d    = cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/urrs_back.sv -----
// ----------------------------------------------------------------------------
// urrs_back
// Piece emitter: walks the head job's pieces one per cycle unless stalled,
// counts them against the table capacity and drives the output register.
// ----------------------------------------------------------------------------
module urrs_back import urrs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   head_valid_i,
  input  job_t   head_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output piece_t out_data_o
);

  logic [2:0]        used_q, used_d, remain, sel;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_base;
  logic              ovf_q, ovf_d, ovf_base;
  logic              out_valid_q, out_valid_d;
  piece_t            out_q, out_d;
  logic              adv, act, clr, emit, last_piece;
  logic [ADDR_W-1:0] p_first, p_end;

  assign adv    = !out_valid_q || !out_stall_i;
  assign act    = adv && head_valid_i;
  assign remain = head_i.mask & ~used_q;
  assign sel    = remain & (~remain + 3'd1);
  assign emit   = act && (remain != 3'b000);
  assign last_piece = (remain & ~sel) == 3'b000;
  assign clr    = head_i.first && (used_q == 3'b000);
  assign pop_o  = act && last_piece;

  assign cnt_base = clr ? '0 : cnt_q;
  assign ovf_base = clr ? 1'b0 : ovf_q;

  always_comb begin
    p_first = head_i.span_start;
    p_end   = head_i.span_last;
    case (sel)
      3'b001: begin
        p_first = head_i.span_start;
        p_end   = head_i.single ? head_i.span_last : cfg_i.win_open - ADDR_W'(1);
      end
      3'b010: begin
        p_first = head_i.start_gt_rs ? head_i.span_start : cfg_i.win_open;
        p_end   = head_i.last_lt_rl ? head_i.span_last : cfg_i.win_close - ADDR_W'(1);
      end
      3'b100: begin
        p_first = cfg_i.win_close;
        p_end   = head_i.span_last;
      end
      default: begin
        p_first = head_i.span_start;
        p_end   = head_i.span_last;
      end
    endcase
  end

  always_comb begin
    used_d      = used_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = adv ? 1'b0 : out_valid_q;
    out_d       = out_q;
    if (act) begin
      used_d = last_piece ? 3'b000 : (used_q | sel);
      cnt_d  = cnt_base;
      ovf_d  = ovf_base;
      if (emit) begin
        if (cnt_base >= TABLE_CAP_C) begin
          ovf_d = 1'b1;
        end else begin
          cnt_d = cnt_base + CNT_W'(1);
        end
        out_valid_d          = 1'b1;
        out_d.piece_addr     = p_first;
        out_d.piece_len      = p_end - p_first + ADDR_W'(1);
        out_d.piece_reserved = sel[1];
        out_d.piece_last     = last_piece;
        out_d.table_overflow = ovf_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= 3'b000;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= TABLE_CAP_C)
    else $error("piece count above capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == TABLE_CAP_C))
    else $error("overflow flagged with table not full");

  a_used_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != 3'b000) |-> (head_valid_i && ((used_q & ~head_i.mask) == 3'b000)))
    else $error("piece walk state without matching job");

  a_emit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("emitted piece not presented");
`endif

endmodule

// ----- rtl/core/usable_range_reservation_splitter_unit.sv -----
// ----------------------------------------------------------------------------
// usable_range_reservation_splitter_unit
// Splits usable memory-map entries into section pieces around one reserved
// window.
// ----------------------------------------------------------------------------
// Entries enter a two-stage classifier, one per cycle unless in_stall_o is
// high, and queue as jobs in a four-deep FIFO; the emitter drains one piece
// per cycle unless out_stall_i is high. A kept entry yields one to three
// pieces; a dropped entry with first_entry set is queued as a job with no
// pieces, other dropped entries are not. The single piece emitter sets the
// sustained rate; pieces pass both stages, the FIFO and a registered output.
// Registers may be written only while no entry is in flight.
module usable_range_reservation_splitter_unit import urrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  entry_t               in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output piece_t               out_data_o
);

  cfg_t cfg_q, cfg_d;
  logic job_valid, job_ready, head_valid, pop;
  job_t job, head;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SECTION_START:  cfg_d.sec_base  = cfg_data_i;
        CFG_RESERVED_START: cfg_d.win_open  = cfg_data_i;
        CFG_RESERVED_END:   cfg_d.win_close = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  urrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  urrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_o       (head)
  );

  urrs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
